// ----- hdl/srlfo_pkg.sv -----
// Shared types and constants for the smoothed random LFO.
// Used by every module of the block; depends on nothing.
package srlfo_pkg;

	localparam int FREQ_W  = 16;
	localparam int NOISE_W = 16;
	localparam int VAL_W   = 24;
	localparam int RATE_W  = 24;
	localparam int CNT_W   = 24;
	localparam int FSQ_W   = 32;

	// serial divider geometry
	localparam int QUO_W  = 31;
	localparam int DEN_W  = 48;
	localparam int NUM_W  = 66;
	localparam int PROD_W = 56;
	localparam int STEP_W = $clog2(QUO_W + 1);

	localparam logic [CNT_W-1:0]  CNT_MAX         = {CNT_W{1'b1}};
	localparam logic [RATE_W-1:0] FRAG_RATE_RESET = RATE_W'(48000);
	localparam int                QUEUE_DEPTH_DEF = 2;

	// one tick as it travels from the front to the back
	typedef struct packed {
		logic [FREQ_W-1:0]         freq;
		logic signed [NOISE_W-1:0] noise_sample;
		logic                      hold;
		logic [FSQ_W-1:0]          freq_sq;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

// ----- hdl/srlfo_front.sv -----
// Input stage of the smoothed random LFO: takes ticks, flags zero-rate ticks
// and squares the rate. Depends on srlfo_pkg.
module srlfo_front import srlfo_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [FREQ_W-1:0]         freq,
	input  logic signed [NOISE_W-1:0] noise_sample,
	output logic                      push_valid,
	input  logic                      push_ready,
	output item_t                     push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign in_ready   = !valid_s1 || push_ready;
	assign take       = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// hold the stage until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify the tick and square its rate
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.freq         <= freq;
			item_s1.noise_sample <= noise_sample;
			item_s1.hold         <= (freq == '0);
			item_s1.freq_sq      <= freq * freq;
		end
	end

endmodule

// ----- hdl/srlfo_fifo.sv -----
// Short ticket queue between the front and the back of the LFO.
// Depends on srlfo_pkg for the entry type.
module srlfo_fifo import srlfo_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	item_t             entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- hdl/srlfo_div.sv -----
// Radix-2 restoring divider with a saturating 31-bit quotient.
// Depends on srlfo_pkg for widths and request/response types.
module srlfo_div import srlfo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DEN_W:0]    trial;
	logic              fits;
	logic              sat;

	// top bits of the dividend against the divisor: quotient would overflow
	assign sat   = {(DEN_W - (NUM_W - QUO_W))'(0), req.num[NUM_W-1:QUO_W]} >= req.den;
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (req.start) begin
				done_q <= sat;
				busy_q <= !sat;
				step_q <= STEP_W'(QUO_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				busy_q <= (step_q != STEP_W'(1));
				done_q <= (step_q == STEP_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// shift, trial subtract, collect quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= {(DEN_W - (NUM_W - QUO_W))'(0), req.num[NUM_W-1:QUO_W]};
			low_q <= req.num[QUO_W-1:0];
			quo_q <= sat ? {QUO_W{1'b1}} : '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

endmodule

// ----- hdl/srlfo_back.sv -----
// Execution part of the LFO: segment counter, slope and glide arithmetic,
// output register. Depends on srlfo_pkg and srlfo_div.
module srlfo_back import srlfo_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [RATE_W-1:0]        rate,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  item_t                    item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VAL_W-1:0]  lfo_value,
	output logic                     new_segment
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_POS   = 3'd1;
	localparam logic [2:0] ST_CLASS = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_ISSUE = 3'd4;
	localparam logic [2:0] ST_WAIT  = 3'd5;

	localparam logic [1:0] MODE_SLOPE = 2'd0;
	localparam logic [1:0] MODE_RISE  = 2'd1;
	localparam logic [1:0] MODE_FALL  = 2'd2;

	localparam logic signed [VAL_W+8:0] SUM_MAX = (VAL_W+9)'(2**(VAL_W-1) - 1);
	localparam logic signed [VAL_W+8:0] SUM_MIN = -(VAL_W+9)'(2**(VAL_W-1));

	logic [2:0]              state_q;
	logic [1:0]              mode_q;
	item_t                   item_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        next_q;
	logic                    slope_neg_q;
	logic [QUO_W-1:0]        slope_mag_q;
	logic signed [VAL_W-1:0] prev_q;
	logic [40:0]             pos_q;
	logic [DEN_W-1:0]        rsq_q;
	logic [DEN_W-1:0]        den_q;
	logic [CNT_W-1:0]        k_q;
	logic                    d_neg_q;
	logic [PROD_W-1:0]       prod_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] lfo_value_q;
	logic                    new_segment_q;

	logic                    take;
	logic [39:0]             fc;
	logic [DEN_W-1:0]        rsq;
	logic signed [VAL_W:0]   diff;
	logic [CNT_W-1:0]        diff_mag;
	logic signed [VAL_W+8:0] step;
	logic signed [VAL_W+8:0] sum;
	logic signed [VAL_W-1:0] sum_sat;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	srlfo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign item_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign take        = item_valid && item_ready;
	assign out_valid   = out_valid_q;
	assign lfo_value   = lfo_value_q;
	assign new_segment = new_segment_q;

	assign fc  = item_q.freq * next_q;
	assign rsq = rate * rate;

	// new target minus last output, Q3.22
	assign diff = $signed({{2{item_q.noise_sample[NOISE_W-1]}}, item_q.noise_sample, 7'b0})
		- $signed({prev_q[VAL_W-1], prev_q});
	assign diff_mag = diff[VAL_W] ? CNT_W'(-diff) : CNT_W'(diff);

	// glide step applied to the last output, then clamped
	assign step = slope_neg_q ? -$signed({2'b0, div_rsp.quo}) : $signed({2'b0, div_rsp.quo});
	assign sum  = $signed({{9{prev_q[VAL_W-1]}}, prev_q}) + step;
	always_comb begin
		priority if (sum > SUM_MAX) begin
			sum_sat = SUM_MAX[VAL_W-1:0];
		end else if (sum < SUM_MIN) begin
			sum_sat = SUM_MIN[VAL_W-1:0];
		end else begin
			sum_sat = sum[VAL_W-1:0];
		end
	end

	// slope: scaled by 1024 over rate squared; glide: round to nearest
	always_comb begin
		div_req.start = (state_q == ST_ISSUE);
		div_req.den   = den_q;
		if (mode_q == MODE_SLOPE) begin
			div_req.num = {prod_q, 10'b0};
		end else begin
			div_req.num = {10'b0, prod_q + PROD_W'(den_q >> 1)};
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			slope_neg_q <= 1'b0;
			slope_mag_q <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take && item.hold) begin
						out_valid_q <= 1'b1;
					end else if (take) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (mode_q == MODE_SLOPE) begin
							count_q     <= '0;
							slope_neg_q <= d_neg_q;
							slope_mag_q <= div_rsp.quo;
						end else begin
							count_q <= next_q;
							prev_q  <= sum_sat;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					item_q        <= item;
					next_q        <= (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
					lfo_value_q   <= prev_q;
					new_segment_q <= 1'b0;
				end
			end
			ST_POS: begin
				pos_q <= {fc, 1'b0};
				rsq_q <= rsq;
			end
			ST_CLASS: begin
				d_neg_q <= diff[VAL_W];
				priority if (pos_q >= {17'b0, rate}) begin
					mode_q <= MODE_SLOPE;
					k_q    <= diff_mag;
					den_q  <= rsq_q;
				end else if ({pos_q, 1'b0} > {18'b0, rate}) begin
					mode_q <= MODE_FALL;
					k_q    <= rate - pos_q[RATE_W-1:0];
					den_q  <= {25'b0, item_q.freq, 7'b0};
				end else begin
					mode_q <= MODE_RISE;
					k_q    <= next_q;
					den_q  <= DEN_W'(64);
				end
			end
			ST_MUL: begin
				if (mode_q == MODE_SLOPE) begin
					prod_q <= k_q * item_q.freq_sq;
				end else begin
					prod_q <= k_q * slope_mag_q;
				end
			end
			ST_ISSUE: begin
			end
			ST_WAIT: begin
				if (div_rsp.done) begin
					if (mode_q == MODE_SLOPE) begin
						lfo_value_q   <= prev_q;
						new_segment_q <= 1'b1;
					end else begin
						lfo_value_q   <= sum_sat;
						new_segment_q <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/smoothed_random_lfo.sv -----
// Top level of the smoothed random LFO: rate register, front, queue, back.
// Depends on srlfo_pkg, srlfo_front, srlfo_fifo and srlfo_back.
//
// Each input transfer is one LFO update tick and gives exactly one output
// transfer. A tick reaches the back through the front register and the queue.
// A tick with freq zero repeats the last value and has its result in the cycle
// after the back takes it. Any other tick has its result after four setup
// steps, the 31-step serial divider that forms either a new slope (at a segment
// end) or the rounded glide step, and the write-back. A quotient that would
// overflow skips the divider steps and saturates. The back cannot take the next
// tick before its result has transferred. The front and a short queue keep
// taking ticks while the back works or its result waits to be taken. frag_rate
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// no tick is in flight, which the block does not enforce. Zero acts as one.
module smoothed_random_lfo import srlfo_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [RATE_W-1:0]         cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [FREQ_W-1:0]         freq,
	input  logic signed [NOISE_W-1:0] noise_sample,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VAL_W-1:0]   lfo_value,
	output logic                      new_segment
);

	logic [RATE_W-1:0] frag_rate_q;
	logic [RATE_W-1:0] rate;
	logic              push_valid;
	logic              push_ready;
	item_t             push_item;
	logic              pop_valid;
	logic              pop_ready;
	item_t             pop_item;

	// hold the rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_rate_q <= FRAG_RATE_RESET;
		end else if (cfg_wr_en) begin
			frag_rate_q <= cfg_wr_data;
		end
	end

	assign rate = (frag_rate_q == '0) ? RATE_W'(1) : frag_rate_q;

	srlfo_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.freq         (freq),
		.noise_sample (noise_sample),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	srlfo_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	srlfo_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rate        (rate),
		.item_valid  (pop_valid),
		.item_ready  (pop_ready),
		.item        (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.lfo_value   (lfo_value),
		.new_segment (new_segment)
	);

endmodule
